@@ design/ybt_pkg.sv @@
// Shared types, constants and helpers of the YCbCr block tiler.
package ybt_pkg;

  // Default array limits, handed to the top-level parameters.
  localparam int unsigned DefMaxWidth  = 64;
  localparam int unsigned DefMaxHeight = 64;
  localparam int unsigned DefMaxBlock  = 8;

  // Fixed field widths.
  localparam int unsigned PosW     = 6;
  localparam int unsigned DimW     = 7;
  localparam int unsigned BlkW     = 4;
  localparam int unsigned CoordW   = 7;
  localparam int unsigned PixW     = 24;
  localparam int unsigned SampleW  = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 7;
  localparam int unsigned InDataW  = 64;
  localparam int unsigned InUserW  = 2;
  localparam int unsigned OutDataW = 16;

  typedef enum logic [1:0] {
    OP_WR_RGB  = 2'd0,
    OP_WR_YCC  = 2'd1,
    OP_EXTRACT = 2'd2
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_BLOCK_SIZE   = 3'd2,
    REG_BORDER_MODE  = 3'd3,
    REG_CHANNEL      = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    CH_Y  = 2'd0,
    CH_CB = 2'd1,
    CH_CR = 2'd2
  } chan_e;

  typedef enum logic {
    CMD_WRITE   = 1'b0,
    CMD_EXTRACT = 1'b1
  } cmd_kind_e;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_RUN  = 1'b1
  } bk_state_e;

  typedef struct packed {
    logic [DimW-1:0] image_width;
    logic [DimW-1:0] image_height;
    logic [BlkW-1:0] block_size;
    logic            border_mode;
    logic [1:0]      channel;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    image_width:  7'd64,
    image_height: 7'd64,
    block_size:   4'd8,
    border_mode:  1'b0,
    channel:      2'd0
  };

  typedef struct packed {
    cmd_kind_e       kind;
    logic [PosW-1:0] pos_x;
    logic [PosW-1:0] pos_y;
    logic [PixW-1:0] rgb;
  } cmd_t;

  typedef struct packed {
    logic busy;          // extraction sequencer is walking a block
    logic drained;       // no sample in flight or waiting at the output
    logic push_blocked;  // a finished sample found the output queue full
  } bk_status_t;

  // YCbCr to RGB, integer form.
  localparam logic signed [18:0] YccKc  = 19'sd298;
  localparam logic signed [18:0] YccKre = 19'sd409;
  localparam logic signed [18:0] YccKgd = 19'sd100;
  localparam logic signed [18:0] YccKge = 19'sd208;
  localparam logic signed [18:0] YccKbd = 19'sd516;
  localparam logic signed [18:0] YccRnd = 19'sd128;

  // RGB to studio-range YCbCr in Q8.8, scaled by 1000.
  localparam logic signed [17:0] KyR  = 18'sd65738;
  localparam logic signed [17:0] KyG  = 18'sd129057;
  localparam logic signed [17:0] KyB  = 18'sd25064;
  localparam logic signed [17:0] KcbR = -18'sd37945;
  localparam logic signed [17:0] KcbG = -18'sd74494;
  localparam logic signed [17:0] KcbB = 18'sd112439;
  localparam logic signed [17:0] KcrR = 18'sd112439;
  localparam logic signed [17:0] KcrG = -18'sd94154;
  localparam logic signed [17:0] KcrB = -18'sd18285;

  // Offsets with the half-up rounding bias of 500 folded in.
  localparam logic signed [27:0] OffY = 28'sd4096500;
  localparam logic signed [27:0] OffC = 28'sd32768500;

  // floor(t / 1000) = (t * RecipMul) >> RecipShift, exact for t < 2**26.
  localparam int unsigned  RecipShift = 36;
  localparam logic [26:0]  RecipMul   = 27'd68719477;

  // Width or height in use: zero acts as one, above the limit as the limit.
  function automatic logic [DimW-1:0] clamp_dim(logic [DimW-1:0] v, int unsigned hi);
    logic [DimW-1:0] r;
    if (v == '0) begin
      r = DimW'(1);
    end else if (32'(v) > hi) begin
      r = DimW'(hi);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

@@ design/ybt_ram.sv @@
// Generic single-port RAM with registered read data.
module ybt_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/ybt_fifo.sv @@
// Small register FIFO used for the command queue and the output queue.
module ybt_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             push, pop;

  assign push_ready_o = (count_q < CntW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ design/ybt_front.sv @@
// Front end: accepts requests, drops void ones, converts YCbCr writes to RGB.
module ybt_front #(
  parameter int unsigned MAX_WIDTH  = ybt_pkg::DefMaxWidth,
  parameter int unsigned MAX_HEIGHT = ybt_pkg::DefMaxHeight
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ybt_pkg::cfg_t                cfg_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   in_op_i,
  input  logic [ybt_pkg::InDataW-1:0]  in_data_i,
  output logic                         cmd_valid_o,
  input  logic                         cmd_ready_i,
  output ybt_pkg::cmd_t                cmd_o
);

  import ybt_pkg::*;

  function automatic logic [7:0] clip8(logic signed [18:0] v);
    logic [7:0] r;
    if (v < 0) begin
      r = 8'd0;
    end else if (v[18:8] > 11'd255) begin
      r = 8'hFF;
    end else begin
      r = v[15:8];
    end
    return r;
  endfunction

  logic [PosW-1:0]   pos_x, pos_y;
  logic [7:0]        red, green, blue, luma, cb, cr;
  logic [DimW-1:0]   w, h;
  logic              in_image, keep, is_write, take, accept;
  logic signed [8:0] c, d, e;

  // Stage 1: classified request plus conversion products.
  logic              s1_valid_q;
  cmd_kind_e         s1_kind_q;
  logic              s1_ycc_q;
  logic [PosW-1:0]   s1_x_q, s1_y_q;
  logic [PixW-1:0]   s1_rgb_q;
  logic signed [18:0] p_c_q, p_re_q, p_gd_q, p_ge_q, p_bd_q;

  // Stage 2: finished command for the queue.
  logic              cmd_valid_q;
  cmd_t              cmd_q, cmd_d;
  logic signed [18:0] sum_r, sum_g, sum_b;

  assign pos_x = in_data_i[5:0];
  assign pos_y = in_data_i[11:6];
  assign red   = in_data_i[19:12];
  assign green = in_data_i[27:20];
  assign blue  = in_data_i[35:28];
  assign luma  = in_data_i[43:36];
  assign cb    = in_data_i[51:44];
  assign cr    = in_data_i[59:52];

  assign w = clamp_dim(cfg_i.image_width, MAX_WIDTH);
  assign h = clamp_dim(cfg_i.image_height, MAX_HEIGHT);

  assign in_image = ({1'b0, pos_x} < w) && ({1'b0, pos_y} < h);
  assign is_write = (in_op_i == OP_WR_RGB) || (in_op_i == OP_WR_YCC);
  assign keep     = (is_write && in_image) || (in_op_i == OP_EXTRACT);

  assign c = $signed({1'b0, luma}) - 9'sd16;
  assign d = $signed({1'b0, cb}) - 9'sd128;
  assign e = $signed({1'b0, cr}) - 9'sd128;

  // The command register moves on when empty or taken; stage 1 follows it.
  assign take       = !cmd_valid_q || cmd_ready_i;
  assign in_ready_o = !s1_valid_q || take;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      cmd_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i && keep;
      end
      if (take) begin
        cmd_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_kind_q <= (in_op_i == OP_EXTRACT) ? CMD_EXTRACT : CMD_WRITE;
      s1_ycc_q  <= (in_op_i == OP_WR_YCC);
      s1_x_q    <= pos_x;
      s1_y_q    <= pos_y;
      s1_rgb_q  <= {red, green, blue};
      p_c_q     <= 19'(c) * YccKc;
      p_re_q    <= 19'(e) * YccKre;
      p_gd_q    <= 19'(d) * YccKgd;
      p_ge_q    <= 19'(e) * YccKge;
      p_bd_q    <= 19'(d) * YccKbd;
    end
    if (take && s1_valid_q) begin
      cmd_q <= cmd_d;
    end
  end

  assign sum_r = p_c_q + p_re_q + YccRnd;
  assign sum_g = p_c_q - p_gd_q - p_ge_q + YccRnd;
  assign sum_b = p_c_q + p_bd_q + YccRnd;

  always_comb begin
    cmd_d.kind  = s1_kind_q;
    cmd_d.pos_x = s1_x_q;
    cmd_d.pos_y = s1_y_q;
    cmd_d.rgb   = s1_ycc_q ? {clip8(sum_r), clip8(sum_g), clip8(sum_b)} : s1_rgb_q;
  end

  assign cmd_valid_o = cmd_valid_q;
  assign cmd_o       = cmd_q;

endmodule

@@ design/ybt_back.sv @@
// Back end: frame store, block walk sequencer, color pipeline, output queue.
module ybt_back #(
  parameter int unsigned MAX_WIDTH  = ybt_pkg::DefMaxWidth,
  parameter int unsigned MAX_HEIGHT = ybt_pkg::DefMaxHeight,
  parameter int unsigned MAX_BLOCK  = ybt_pkg::DefMaxBlock
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ybt_pkg::cfg_t                cfg_i,
  input  logic                         cmd_valid_i,
  output logic                         cmd_ready_o,
  input  ybt_pkg::cmd_t                cmd_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [ybt_pkg::SampleW-1:0]  out_sample_o,
  output logic                         out_last_o,
  output ybt_pkg::bk_status_t          status_o
);

  import ybt_pkg::*;

  localparam int unsigned Depth    = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AddrW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW     = $clog2(MAX_BLOCK + 1);
  localparam int unsigned OutDepth = 8;
  localparam int unsigned UsedW    = $clog2(OutDepth + 1);
  localparam int unsigned OutW     = SampleW + 1;

  bk_state_e       state_q, state_d;
  logic [CntW-1:0] dx_q, dy_q, n, n_last;
  logic [PosW-1:0] bx_q, by_q;
  logic [UsedW-1:0] used_q, used_d;
  logic [DimW-1:0] w, h;

  logic            start, issue, ram_we, at_last, pop;
  logic [CoordW-1:0] x, y, cx, cy, ax, ay;
  logic            out_x, out_y, zero_tag;
  logic [AddrW-1:0] addr;
  logic [PixW-1:0] rdata;

  // Pipeline registers.
  logic              p1_valid_q, p1_zero_q, p1_last_q;
  logic              p2_valid_q, p2_zero_q, p2_last_q;
  logic              p3_valid_q, p3_zero_q, p3_last_q;
  logic              p4_valid_q, p4_zero_q, p4_last_q;
  logic signed [26:0] prod_r_q, prod_g_q, prod_b_q;
  logic signed [17:0] k_r, k_g, k_b;
  logic              chan_bad;
  logic [25:0]       t_q;
  logic signed [27:0] off, sum;
  logic [52:0]       quot_q;
  logic [OutW-1:0]   push_data, pop_data;
  logic              push_ready;

  assign w = clamp_dim(cfg_i.image_width, MAX_WIDTH);
  assign h = clamp_dim(cfg_i.image_height, MAX_HEIGHT);
  assign n = (32'(cfg_i.block_size) > MAX_BLOCK) ? CntW'(MAX_BLOCK)
                                                 : CntW'(cfg_i.block_size);
  assign n_last = n - 1'b1;

  // Sample position, clamped to the edge for border copy.
  assign x     = CoordW'({1'b0, bx_q}) + CoordW'(dx_q);
  assign y     = CoordW'({1'b0, by_q}) + CoordW'(dy_q);
  assign out_x = (x >= w);
  assign out_y = (y >= h);
  assign cx    = out_x ? w - 1'b1 : x;
  assign cy    = out_y ? h - 1'b1 : y;
  assign zero_tag = (out_x || out_y) && !cfg_i.border_mode;
  assign at_last  = (dx_q == n_last) && (dy_q == n_last);

  // Writes use the command position, reads the walked position.
  assign ax   = (state_q == BK_IDLE) ? CoordW'({1'b0, cmd_i.pos_x}) : cx;
  assign ay   = (state_q == BK_IDLE) ? CoordW'({1'b0, cmd_i.pos_y}) : cy;
  assign addr = AddrW'(ay) * AddrW'(MAX_WIDTH) + AddrW'(ax);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i && (cmd_i.kind == CMD_EXTRACT) && (n != '0)) begin
          state_d = BK_RUN;
        end
      end
      BK_RUN: begin
        if ((used_q < UsedW'(OutDepth)) && at_last) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    cmd_ready_o = 1'b0;
    ram_we      = 1'b0;
    start       = 1'b0;
    issue       = 1'b0;
    case (state_q)
      BK_IDLE: begin
        cmd_ready_o = 1'b1;
        ram_we      = cmd_valid_i && (cmd_i.kind == CMD_WRITE);
        start       = cmd_valid_i && (cmd_i.kind == CMD_EXTRACT) && (n != '0);
      end
      BK_RUN: begin
        // Issue only with a free output slot reserved for the sample.
        issue = (used_q < UsedW'(OutDepth));
      end
      default: ;
    endcase
  end

  assign pop    = out_valid_o && out_ready_i;
  assign used_d = used_q + UsedW'(issue) - UsedW'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= BK_IDLE;
      dx_q       <= '0;
      dy_q       <= '0;
      bx_q       <= '0;
      by_q       <= '0;
      used_q     <= '0;
      p1_valid_q <= 1'b0;
      p2_valid_q <= 1'b0;
      p3_valid_q <= 1'b0;
      p4_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      used_q     <= used_d;
      p1_valid_q <= issue;
      p2_valid_q <= p1_valid_q;
      p3_valid_q <= p2_valid_q;
      p4_valid_q <= p3_valid_q;
      if (start) begin
        dx_q <= '0;
        dy_q <= '0;
        bx_q <= cmd_i.pos_x;
        by_q <= cmd_i.pos_y;
      end else if (issue) begin
        if (dx_q == n_last) begin
          dx_q <= '0;
          dy_q <= dy_q + 1'b1;
        end else begin
          dx_q <= dx_q + 1'b1;
        end
      end
    end
  end

  ybt_ram #(
    .WIDTH (PixW),
    .DEPTH (Depth)
  ) u_frame (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (addr),
    .wdata_i (cmd_i.rgb),
    .rdata_o (rdata)
  );

  always_comb begin
    k_r      = KyR;
    k_g      = KyG;
    k_b      = KyB;
    off      = OffY;
    chan_bad = 1'b0;
    case (chan_e'(cfg_i.channel))
      CH_Y: begin
        k_r = KyR;
        k_g = KyG;
        k_b = KyB;
        off = OffY;
      end
      CH_CB: begin
        k_r = KcbR;
        k_g = KcbG;
        k_b = KcbB;
        off = OffC;
      end
      CH_CR: begin
        k_r = KcrR;
        k_g = KcrG;
        k_b = KcrB;
        off = OffC;
      end
      default: chan_bad = 1'b1;
    endcase
  end

  assign sum = 28'(prod_r_q) + 28'(prod_g_q) + 28'(prod_b_q) + off;

  always_ff @(posedge clk_i) begin
    p1_zero_q <= zero_tag;
    p1_last_q <= at_last;
    // Products of the three components.
    p2_zero_q <= p1_zero_q || chan_bad;
    p2_last_q <= p1_last_q;
    prod_r_q  <= 27'(signed'({1'b0, rdata[23:16]})) * 27'(k_r);
    prod_g_q  <= 27'(signed'({1'b0, rdata[15:8]})) * 27'(k_g);
    prod_b_q  <= 27'(signed'({1'b0, rdata[7:0]})) * 27'(k_b);
    // Offset and rounding bias.
    p3_zero_q <= p2_zero_q || (sum < 0);
    p3_last_q <= p2_last_q;
    t_q       <= sum[25:0];
    // Divide by 1000 through the reciprocal.
    p4_zero_q <= p3_zero_q;
    p4_last_q <= p3_last_q;
    quot_q    <= t_q * RecipMul;
  end

  assign push_data = {p4_last_q,
                      p4_zero_q ? SampleW'(0) : quot_q[RecipShift +: SampleW]};

  ybt_fifo #(
    .WIDTH (OutW),
    .DEPTH (OutDepth)
  ) u_out_q (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (p4_valid_q),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (out_valid_o),
    .pop_ready_i  (out_ready_i),
    .pop_data_o   (pop_data)
  );

  assign out_sample_o = pop_data[SampleW-1:0];
  assign out_last_o   = pop_data[SampleW];

  assign status_o.busy         = (state_q == BK_RUN);
  assign status_o.drained      = (used_q == '0);
  assign status_o.push_blocked = p4_valid_q && !push_ready;

endmodule

@@ design/ycbcr_block_tiler.sv @@
// Top level of the YCbCr block tiler: config registers, front, queue, back.
//
//  channel  | direction | payload
//  ---------+-----------+-------------------------------------------------
//  s_axis   | in        | tuser: op; tdata: position and pixel fields
//  m_axis   | out       | tdata: sample (Q8.8); tlast: final block sample
//  cfg      | in        | cfg_index_i selects the register, cfg_data_i value
//
// A pixel write request passes front stage 1, the command register, the command
// queue and the frame store write; the front takes a new request every cycle
// unless stalled. An extract request of side n gives n*n samples, one per cycle
// unless paused, as the frame store has one port; each is read, multiplied,
// offset and divided. Reset clears control only; the frame store holds garbage
// until written. Either side may stall: the command queue and the output queue
// absorb it, and the walk pauses when the output queue is full.
module ycbcr_block_tiler #(
  parameter int unsigned MAX_WIDTH  = ybt_pkg::DefMaxWidth,
  parameter int unsigned MAX_HEIGHT = ybt_pkg::DefMaxHeight,
  parameter int unsigned MAX_BLOCK  = ybt_pkg::DefMaxBlock
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Request stream.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // tdata, from bit 0: pos_x[5:0], pos_y[11:6], red[19:12], green[27:20],
  // blue[35:28], luma[43:36], chroma_blue[51:44], chroma_red[59:52], zeros
  input  logic [ybt_pkg::InDataW-1:0]   s_axis_tdata,
  // tuser: op[1:0]
  input  logic [ybt_pkg::InUserW-1:0]   s_axis_tuser,
  // Sample stream.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // tdata: sample[15:0]
  output logic [ybt_pkg::OutDataW-1:0]  m_axis_tdata,
  output logic                          m_axis_tlast,
  // Register write port.
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ybt_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [ybt_pkg::CfgDataW-1:0]  cfg_data_i
);

  import ybt_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic       front_valid, q_push_ready;
  cmd_t       front_cmd, q_cmd;
  logic       q_pop_valid, q_pop_ready;
  logic [$bits(cmd_t)-1:0] q_pop_data;
  bk_status_t bk_status;

  // Registers take a write on every request; unknown indexes drop it.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    case (cfg_reg_e'(cfg_index_i))
      REG_IMAGE_WIDTH:  cfg_d.image_width  = cfg_data_i[DimW-1:0];
      REG_IMAGE_HEIGHT: cfg_d.image_height = cfg_data_i[DimW-1:0];
      REG_BLOCK_SIZE:   cfg_d.block_size   = cfg_data_i[BlkW-1:0];
      REG_BORDER_MODE:  cfg_d.border_mode  = cfg_data_i[0];
      REG_CHANNEL:      cfg_d.channel      = cfg_data_i[1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      cfg_q <= cfg_d;
    end
  end

  // Front: classify requests, convert YCbCr pixels, drop void requests.
  ybt_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_op_i     (s_axis_tuser),
    .in_data_i   (s_axis_tdata),
    .cmd_valid_o (front_valid),
    .cmd_ready_i (q_push_ready),
    .cmd_o       (front_cmd)
  );

  // Short command queue; keeps writes and extracts in request order.
  ybt_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (2)
  ) u_cmd_q (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (q_push_ready),
    .push_data_i  (front_cmd),
    .pop_valid_o  (q_pop_valid),
    .pop_ready_i  (q_pop_ready),
    .pop_data_o   (q_pop_data)
  );

  assign q_cmd = cmd_t'(q_pop_data);

  // Back: frame store access, block walk and color conversion.
  ybt_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_BLOCK  (MAX_BLOCK)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .cmd_valid_i  (q_pop_valid),
    .cmd_ready_o  (q_pop_ready),
    .cmd_i        (q_cmd),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_sample_o (m_axis_tdata),
    .out_last_o   (m_axis_tlast),
    .status_o     (bk_status)
  );

  // A command stalled at the queue must hold until the queue takes it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_valid && !q_push_ready |=> front_valid && $stable(front_cmd))
    else $error("front command changed while stalled");

  // The credit count must cover every sample in the output queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_status.drained |-> !m_axis_tvalid)
    else $error("sample at output with no credit outstanding");

  // The reserved slot must always be there when a sample finishes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !bk_status.push_blocked)
    else $error("finished sample found output queue full");

  // A block walk starts only from a command taken off the queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(bk_status.busy) |-> $past(q_pop_valid && q_pop_ready))
    else $error("block walk started without a command");

endmodule
